/* rtl/riff_wave_header_parser_unit_macros.svh */
// ---------------------------------------------------------------------------
// riff_wave_header_parser_unit_macros
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef RIFF_WAVE_HEADER_PARSER_UNIT_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define RWH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rwh_pkg.sv */
// ---------------------------------------------------------------------------
// rwh_pkg
// shared types, codes and constants of the riff/wave header parser
// ---------------------------------------------------------------------------
package rwh_pkg;

  localparam int DIV_DW = 42;
  localparam int DIV_VW = 32;
  localparam int MS_PER_S = 1000;
  localparam int FMT_BYTES = 16;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_NO_DATA = 2'd2;

  typedef enum logic [1:0] {
    SEL_CH,
    SEL_BITS,
    SEL_RATE
  } div_sel_t;

  typedef struct packed {
    logic       shift_en;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       len_load;
    logic       len_sub16;
    logic       len_dec;
    logic       fmt_wr;
    logic       clear_file;
    logic       pos_inc;
    logic       emit_data;
    logic       emit_status;
    logic [1:0] status_code;
    logic       div_start;
    div_sel_t   div_sel;
    logic       samp_load;
    logic       samp_zero;
    logic       ms_load;
    logic       ms_zero;
  } cmd_t;

  typedef struct packed {
    logic cnt3;
    logic cnt11;
    logic cnt15;
    logic riff_ok;
    logic wave_ok;
    logic fmt_id;
    logic data_id;
    logic word_zero;
    logic len_gt16;
    logic len_one;
    logic ch_zero;
    logic bits_zero;
    logic rate_zero;
    logic div_done;
  } stat_t;

endpackage

/* rtl/rwh_div.sv */
// ---------------------------------------------------------------------------
// rwh_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rwh_div #(
  parameter int DW = rwh_pkg::DIV_DW,
  parameter int VW = rwh_pkg::DIV_VW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] count;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          ge;

  assign rem_sh = {rem, quotient[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = ~diff[VW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= CW'(DW - 1);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
        quotient <= {quotient[DW-2:0], ge};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/rwh_dpath.sv */
// ---------------------------------------------------------------------------
// rwh_dpath
// byte shifter, counters, fmt capture, result registers and divider
// ---------------------------------------------------------------------------
module rwh_dpath (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     data_byte,
  input  rwh_pkg::cmd_t  cmd,
  output rwh_pkg::stat_t st,
  output logic [1:0]     res_status,
  output logic [255:0]   res_data
);
  import rwh_pkg::*;

  logic [31:0] word_shift;
  logic [31:0] shift_next;
  logic [3:0]  byte_counter;
  logic [31:0] chunk_length;
  logic [31:0] file_position;
  logic [7:0]  fmt_byte [FMT_BYTES];

  logic [15:0] res_tag;
  logic [15:0] res_ch;
  logic [31:0] res_rate;
  logic [31:0] res_brate;
  logic [15:0] res_align;
  logic [15:0] res_bits;
  logic [31:0] res_offset;
  logic [31:0] res_size;
  logic [31:0] res_ms;
  logic [31:0] res_samples;

  logic [DIV_DW-1:0] div_num;
  logic [DIV_VW-1:0] div_den;
  logic [DIV_DW-1:0] quotient;
  logic              div_done;
  logic [DIV_DW-1:0] ms_num;

  assign shift_next = {data_byte, word_shift[31:8]};
  assign ms_num     = {10'd0, res_size} * DIV_DW'(MS_PER_S);

  always_comb begin
    st.cnt3      = (byte_counter == 4'd3);
    st.cnt11     = (byte_counter == 4'd11);
    st.cnt15     = (byte_counter == 4'd15);
    st.riff_ok   = (shift_next == TAG_RIFF);
    st.wave_ok   = (shift_next == TAG_WAVE);
    st.fmt_id    = (shift_next == TAG_FMT);
    st.data_id   = (shift_next == TAG_DATA);
    st.word_zero = (shift_next == 32'd0);
    st.len_gt16  = (chunk_length > 32'(FMT_BYTES));
    st.len_one   = (chunk_length == 32'd1);
    st.ch_zero   = (res_ch == 16'd0);
    st.bits_zero = (res_bits == 16'd0);
    st.rate_zero = (res_brate == 32'd0);
    st.div_done  = div_done;
  end

  always_comb begin
    unique case (cmd.div_sel)
      SEL_CH: begin
        div_num = {10'd0, res_size};
        div_den = {16'd0, res_ch};
      end
      SEL_BITS: begin
        div_num = {10'd0, quotient[28:0], 3'b000};
        div_den = {16'd0, res_bits};
      end
      SEL_RATE: begin
        div_num = ms_num;
        div_den = res_brate;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  rwh_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_file) begin
      word_shift    <= '0;
      byte_counter  <= '0;
      chunk_length  <= '0;
      file_position <= '0;
      for (int i = 0; i < FMT_BYTES; i++) fmt_byte[i] <= '0;
    end else begin
      if (cmd.pos_inc) file_position <= file_position + 32'd1;
      if (cmd.shift_en) word_shift <= shift_next;
      if (cmd.cnt_clr) byte_counter <= '0;
      else if (cmd.cnt_inc) byte_counter <= byte_counter + 4'd1;
      if (cmd.len_load) chunk_length <= shift_next;
      else if (cmd.len_sub16) chunk_length <= chunk_length - 32'(FMT_BYTES);
      else if (cmd.len_dec) chunk_length <= chunk_length - 32'd1;
      if (cmd.fmt_wr) fmt_byte[byte_counter] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      res_status  <= cmd.status_code;
      res_tag     <= '0;
      res_ch      <= '0;
      res_rate    <= '0;
      res_brate   <= '0;
      res_align   <= '0;
      res_bits    <= '0;
      res_offset  <= '0;
      res_size    <= '0;
      res_ms      <= '0;
      res_samples <= '0;
    end else if (cmd.emit_data) begin
      res_status <= ST_FOUND;
      res_tag    <= {fmt_byte[1], fmt_byte[0]};
      res_ch     <= {fmt_byte[3], fmt_byte[2]};
      res_rate   <= {fmt_byte[7], fmt_byte[6], fmt_byte[5], fmt_byte[4]};
      res_brate  <= {fmt_byte[11], fmt_byte[10], fmt_byte[9], fmt_byte[8]};
      res_align  <= {fmt_byte[13], fmt_byte[12]};
      res_bits   <= {fmt_byte[15], fmt_byte[14]};
      res_offset <= file_position + 32'd1;
      res_size   <= shift_next;
    end else begin
      if (cmd.samp_zero) res_samples <= '0;
      else if (cmd.samp_load) res_samples <= quotient[31:0];
      if (cmd.ms_zero) res_ms <= '0;
      else if (cmd.ms_load) res_ms <= (quotient[41:32] != 10'd0) ? '1 : quotient[31:0];
    end
  end

  assign res_data = {res_samples, res_ms, res_size, res_offset,
                     res_bits, res_align, res_brate, res_rate, res_ch, res_tag};

endmodule

/* rtl/rwh_ctrl.sv */
// ---------------------------------------------------------------------------
// rwh_ctrl
// parse phase sequencer, division sequencer and output handshake
// ---------------------------------------------------------------------------
module rwh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rwh_pkg::stat_t st,
  output rwh_pkg::cmd_t  cmd
);
  import rwh_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER, PH_FMT, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OP_PARSE, OP_DIV1, OP_WAIT1, OP_DIV2, OP_WAIT2, OP_DIV3, OP_WAIT3
  } op_t;

  phase_t phase, phase_next;
  op_t    op, op_next;
  logic   header_bad, bad_set;
  logic   accept;
  logic   emit;

  assign in_ready = (op == OP_PARSE) && !out_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.div_sel = SEL_CH;
    phase_next  = phase;
    op_next     = op;
    bad_set     = 1'b0;
    emit        = 1'b0;
    if (accept) begin
      cmd.pos_inc = 1'b1;
      unique case (phase)
        PH_HEADER: begin
          cmd.shift_en = 1'b1;
          if (st.cnt3 && !st.riff_ok) bad_set = 1'b1;
          if (st.cnt11) begin
            cmd.cnt_clr = 1'b1;
            if (header_bad || !st.wave_ok) begin
              cmd.emit_status = 1'b1;
              cmd.status_code = ST_BAD_HDR;
              emit            = 1'b1;
              phase_next      = PH_DONE;
            end else begin
              phase_next = PH_ID;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
        PH_ID: begin
          cmd.shift_en = 1'b1;
          if (st.cnt3) begin
            cmd.cnt_clr = 1'b1;
            if (st.fmt_id) phase_next = PH_SZ_FMT;
            else if (st.data_id) phase_next = PH_SZ_DATA;
            else phase_next = PH_SZ_OTHER;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
        PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
          cmd.shift_en = 1'b1;
          if (st.cnt3) begin
            cmd.cnt_clr  = 1'b1;
            cmd.len_load = 1'b1;
            if (phase == PH_SZ_FMT) begin
              phase_next = PH_FMT;
            end else if (phase == PH_SZ_DATA) begin
              cmd.emit_data = 1'b1;
              emit          = 1'b1;
              op_next       = OP_DIV1;
              phase_next    = PH_DONE;
            end else begin
              phase_next = st.word_zero ? PH_ID : PH_SKIP;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
        PH_FMT: begin
          cmd.fmt_wr = 1'b1;
          if (st.cnt15) begin
            cmd.cnt_clr = 1'b1;
            if (st.len_gt16) begin
              cmd.len_sub16 = 1'b1;
              phase_next    = PH_SKIP;
            end else begin
              phase_next = PH_ID;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
        PH_SKIP: begin
          cmd.len_dec = 1'b1;
          if (st.len_one) phase_next = PH_ID;
        end
        default: ;
      endcase
      if (in_last) begin
        if (!emit && phase_next != PH_DONE) begin
          cmd.emit_status = 1'b1;
          cmd.status_code = (phase_next == PH_HEADER && (header_bad || bad_set)) ?
                            ST_BAD_HDR : ST_NO_DATA;
        end
        cmd.clear_file = 1'b1;
        phase_next     = PH_HEADER;
      end
    end else begin
      unique case (op)
        OP_DIV1: begin
          if (st.ch_zero || st.bits_zero) begin
            cmd.samp_zero = 1'b1;
            op_next       = OP_DIV3;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_CH;
            op_next       = OP_WAIT1;
          end
        end
        OP_WAIT1: if (st.div_done) op_next = OP_DIV2;
        OP_DIV2: begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_BITS;
          op_next       = OP_WAIT2;
        end
        OP_WAIT2: begin
          if (st.div_done) begin
            cmd.samp_load = 1'b1;
            op_next       = OP_DIV3;
          end
        end
        OP_DIV3: begin
          if (st.rate_zero) begin
            cmd.ms_zero = 1'b1;
            op_next     = OP_PARSE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_RATE;
            op_next       = OP_WAIT3;
          end
        end
        OP_WAIT3: begin
          if (st.div_done) begin
            cmd.ms_load = 1'b1;
            op_next     = OP_PARSE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      op         <= OP_PARSE;
      header_bad <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      op    <= op_next;
      if (cmd.clear_file) header_bad <= 1'b0;
      else if (bad_set) header_bad <= 1'b1;
      if (cmd.emit_status || cmd.ms_zero || cmd.ms_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/riff_wave_header_parser_unit.sv */
// ---------------------------------------------------------------------------
// riff_wave_header_parser_unit
// parses the riff/wave header of a byte stream and reports format and length
// ---------------------------------------------------------------------------
// the input stream carries one file byte per transfer, tlast on the final byte
// of each file. for every file one result transfer comes out: tuser holds the
// status, tdata the fmt fields, data offset and size, total ms and samples.
// header bytes are taken one per cycle. a result with a bad or missing status
// appears in the cycle after the byte that causes it. a data chunk result needs
// the shared divider up to three times, fewer when a divisor is zero, and comes
// out once the division sequence ends. while the divider runs or a result
// waits, s_tready is low; the byte stream then resumes at one per cycle. after
// the result the rest of the file is consumed one byte a cycle.
// reset returns the parser to the header phase with no result pending.
// a stalled receiver holds the result in the output register and the input
// stays stalled until that transfer completes.
// ---------------------------------------------------------------------------
module riff_wave_header_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // format_tag, channel_count, sample_rate, byte_rate, block_align,
  // sample_bits, data_offset, data_size, total_ms, total_samples
  output logic [255:0] m_tdata,
  output logic [1:0]   m_tuser    // status
);
  import rwh_pkg::*;

  `include "riff_wave_header_parser_unit_macros.svh"

  cmd_t  cmd;
  stat_t st;

  rwh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rwh_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (s_tdata),
    .cmd        (cmd),
    .st         (st),
    .res_status (m_tuser),
    .res_data   (m_tdata)
  );

  `RWH_ASSERT_NOW(a_no_accept_while_pending, s_tready, !m_tvalid, "input taken with result pending")
  `RWH_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3, "illegal status code")
  `RWH_ASSERT_NOW(a_error_zero, m_tvalid && m_tuser != ST_FOUND, m_tdata == '0, "error result not zero")
  `RWH_ASSERT_NOW(a_ms_zero_rate, m_tvalid && m_tdata[95:64] == 32'd0, m_tdata[223:192] == 32'd0, "ms with zero byte rate")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench for riff_wave_header_parser_unit
// streams generated wav files byte by byte, predicts each parser result and
// checks the status and every 32-bit tdata word of each result transfer under random idling and stalls
// ---------------------------------------------------------------------------
module testbench;
  import rwh_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER, PH_FMT, PH_SKIP, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [255:0] fields;
  } wav_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [255:0] m_tdata;
  logic [1:0]   m_tuser;

  riff_wave_header_parser_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  byte_item_t  byte_queue[$];
  wav_result_t expected_results[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  bit          failed;
  bit          stim_done;

  // parser model state
  phase_t      ph;
  logic [31:0] cnt, pos, shreg, clen;
  logic        hbad;
  logic [7:0]  fmt_mem [16];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] fmt_half(int i);
    return {fmt_mem[(i + 1) & 15], fmt_mem[i & 15]};
  endfunction

  function automatic logic [31:0] fmt_word(int i);
    return {fmt_half(i + 2), fmt_half(i)};
  endfunction

  function automatic void clear_file_state();
    ph = PH_HEADER;
    cnt = 0; pos = 0; shreg = 0; clen = 0; hbad = 0;
    foreach (fmt_mem[i]) fmt_mem[i] = 0;
  endfunction

  function automatic wav_result_t data_result(logic [31:0] size);
    wav_result_t r;
    logic [15:0] ch, bits;
    logic [31:0] rate, samples, q;
    logic [63:0] ms;
    ch = fmt_half(2);
    rate = fmt_word(8);
    bits = fmt_half(14);
    ms = 0;
    samples = 0;
    if (rate != 0) begin
      ms = (64'(size) * 64'(MS_PER_S)) / 64'(rate);
      if (ms > 64'hFFFF_FFFF) ms = 64'hFFFF_FFFF;
    end
    if (ch != 0 && bits != 0) begin
      q = (size / 32'(ch)) * 32'd8;
      samples = q / 32'(bits);
    end
    r.status = ST_FOUND;
    r.fields = {32'(samples), ms[31:0], size, pos, bits, fmt_half(12), rate,
                fmt_word(4), ch, fmt_half(0)};
    return r;
  endfunction

  function automatic void predict_byte(byte_item_t it);
    wav_result_t r;
    bit emitted;
    emitted = 0;
    pos = pos + 1;
    case (ph)
      PH_HEADER: begin
        shreg = {it.data, shreg[31:8]};
        if (cnt == 3 && shreg != TAG_RIFF) hbad = 1;
        if (cnt == 11) begin
          if (shreg != TAG_WAVE) hbad = 1;
          cnt = 0;
          if (hbad) begin
            r = '0; r.status = ST_BAD_HDR;
            expected_results.push_back(r);
            emitted = 1;
            ph = PH_DONE;
          end else ph = PH_ID;
        end else cnt++;
      end
      PH_ID: begin
        shreg = {it.data, shreg[31:8]};
        if (cnt == 3) begin
          cnt = 0;
          if (shreg == TAG_FMT) ph = PH_SZ_FMT;
          else if (shreg == TAG_DATA) ph = PH_SZ_DATA;
          else ph = PH_SZ_OTHER;
        end else cnt++;
      end
      PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
        shreg = {it.data, shreg[31:8]};
        if (cnt == 3) begin
          cnt = 0;
          clen = shreg;
          if (ph == PH_SZ_FMT) ph = PH_FMT;
          else if (ph == PH_SZ_DATA) begin
            expected_results.push_back(data_result(clen));
            emitted = 1;
            ph = PH_DONE;
          end else ph = (clen == 0) ? PH_ID : PH_SKIP;
        end else cnt++;
      end
      PH_FMT: begin
        fmt_mem[cnt & 15] = it.data;
        if (cnt >= FMT_BYTES - 1) begin
          cnt = 0;
          if (clen > FMT_BYTES) begin
            clen = clen - FMT_BYTES;
            ph = PH_SKIP;
          end else ph = PH_ID;
        end else cnt++;
      end
      PH_SKIP: begin
        clen = clen - 1;
        if (clen == 0) ph = PH_ID;
      end
      default: ;
    endcase
    if (it.last) begin
      if (!emitted && ph != PH_DONE) begin
        r = '0;
        r.status = (ph == PH_HEADER && hbad) ? ST_BAD_HDR : ST_NO_DATA;
        expected_results.push_back(r);
      end
      clear_file_state();
    end
  endfunction

  // byte list for one file under construction
  logic [7:0] file_bytes[$];

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_fmt(logic [31:0] size, bit rand_fields);
    put_word(TAG_FMT);
    put_word(size);
    for (int i = 0; i < 16; i++) begin
      if (rand_fields) file_bytes.push_back(8'($urandom_range(0, 255)));
      else file_bytes.push_back(i == 2 ? 8'd2 : i == 8 ? 8'h10 : i == 14 ? 8'd16 : 8'd0);
    end
    if (size > 16) for (int i = 16; i < size; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic queue_file(int tail);
    byte_item_t it;
    for (int i = 0; i < tail; i++) file_bytes.push_back(8'($urandom));
    if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
    foreach (file_bytes[i]) begin
      it.data = file_bytes[i];
      it.last = (i == file_bytes.size() - 1);
      byte_queue.push_back(it);
    end
    file_bytes.delete();
  endtask

  task automatic put_header();
    put_word(TAG_RIFF); put_word($urandom); put_word(TAG_WAVE);
  endtask

  // well-formed file with random content, sometimes cut or corrupted
  task automatic random_file();
    int kind, nchunks;
    logic [31:0] sz;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      for (int i = 0; i < $urandom_range(1, 20); i++) file_bytes.push_back(8'($urandom));
      queue_file(0);
      return;
    end
    put_header();
    if (kind < 13) file_bytes[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
    nchunks = $urandom_range(0, 2);
    for (int c = 0; c < nchunks; c++) begin
      if ($urandom_range(0, 1)) put_fmt($urandom_range(0, 1) ? 16 : $urandom_range(0, 24), 1);
      else begin
        put_word($urandom);
        sz = $urandom_range(0, 6);
        put_word(sz);
        for (int i = 0; i < sz; i++) file_bytes.push_back(8'($urandom));
      end
    end
    if (kind < 20) begin
      queue_file(0);
      return;
    end
    put_word(TAG_DATA);
    sz = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
    put_word(sz);
    queue_file($urandom_range(0, 6));
  endtask

  task automatic directed_files();
    // minimal valid file, data size at both extremes
    put_header(); put_fmt(16, 0); put_word(TAG_DATA); put_word(32'hFFFF_FFFF); queue_file(0);
    put_header(); put_fmt(16, 0); put_word(TAG_DATA); put_word(0); queue_file(3);
    // extended fmt chunk and short fmt chunk
    put_header(); put_fmt(18, 1); put_word(TAG_DATA); put_word($urandom); queue_file(1);
    put_header(); put_fmt(4, 1); put_word(TAG_DATA); put_word($urandom); queue_file(1);
    // zero divisors: no fmt chunk at all
    put_header(); put_word(TAG_DATA); put_word(12345); queue_file(2);
    // zero-size other chunk, then data
    put_header(); put_word(32'h5453_494c); put_word(0); put_word(TAG_DATA); put_word(7);
    queue_file(0);
    // bad riff, bad wave, early end inside a bad riff, early end after header
    put_header(); file_bytes[0] = 8'h00; queue_file(2);
    put_header(); file_bytes[11] = 8'hFF; queue_file(0);
    put_word(32'h0000_00FF); put_word(0); queue_file(0);
    put_header(); queue_file(0);
    for (int i = 0; i < 5; i++) file_bytes.push_back(8'hFF);
    queue_file(0);
    file_bytes.push_back(8'h00); queue_file(0);
  endtask

  function automatic void check_result(wav_result_t got);
    wav_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t unexpected result: status %0d data %h", $time, got.status, got.fields);
      failed = 1;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
      failed = 1;
    end
    for (int f = 0; f < 8; f++)
      if (got.fields[f*32 +: 32] !== want.fields[f*32 +: 32]) begin
        $display("%0t tdata word %0d: expected %h actual %h", $time, f,
                 want.fields[f*32 +: 32], got.fields[f*32 +: 32]);
        failed = 1;
      end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_byte('{s_tdata, s_tlast});
      if ((!s_tvalid || s_tready) ) begin
        if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          {s_tdata, s_tlast} <= byte_queue.pop_front();
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result('{m_tuser, m_tdata});
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic drain();
    int guard;
    guard = 0;
    while ((byte_queue.size() > 0 || s_tvalid || expected_results.size() > 0) && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 2000000) begin
      $display("Test completed with failures");
      $finish;
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
    send_idle_pct = 12; recv_idle_pct = 46;
    hold_off_cycles = 0;
    failed = 0;
    clear_file_state();
    repeat (7) @(posedge clk);
    rst <= 0;
    directed_files();
    while (byte_queue.size() < 600) random_file();
    drain();
    send_idle_pct = 46; recv_idle_pct = 12;
    while (byte_queue.size() < 600) random_file();
    hold_off_cycles <= 400;
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    while (byte_queue.size() < 550) random_file();
    drain();
    repeat (300) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
